// File: rtl/dur_pkg.sv
// Shared types and constants for the duration text parser.
// Used by dur_parse, dur_accum and duration_string_parser.
`timescale 1ns / 1ps

package dur_pkg;

  localparam int NUM_W_DEF = 64;           // default width of the number register
  localparam int NUM_W_MAX = 64;           // number width carried between modules
  localparam int SCALE_W   = 27;           // wide enough for one day in ms
  localparam int TOTAL_W   = 63;           // total_ms width

  typedef enum logic [2:0] {
    ST_P       = 3'd0,
    ST_DAYS    = 3'd1,
    ST_HOURS   = 3'd2,
    ST_MINUTES = 3'd3,
    ST_SECONDS = 3'd4,
    ST_MILLI   = 3'd5
  } stage_t;

  typedef enum logic [2:0] {
    E_NONE       = 3'd0,
    E_NO_P       = 3'd1,
    E_NO_DIGITS  = 3'd2,
    E_NO_POSTFIX = 3'd3,
    E_ORDER      = 3'd4,
    E_UNKNOWN    = 3'd5,
    E_OVERFLOW   = 3'd6
  } err_t;

  // ASCII codes
  localparam logic [7:0] CH_P   = 8'h50;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_H   = 8'h48;
  localparam logic [7:0] CH_M   = 8'h4D;
  localparam logic [7:0] CH_S   = 8'h53;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  // unit scales in milliseconds
  localparam logic [SCALE_W-1:0] SC_NONE = 27'd0;
  localparam logic [SCALE_W-1:0] SC_DAY  = 27'd86400000;
  localparam logic [SCALE_W-1:0] SC_HOUR = 27'd3600000;
  localparam logic [SCALE_W-1:0] SC_MIN  = 27'd60000;
  localparam logic [SCALE_W-1:0] SC_SEC  = 27'd1000;
  localparam logic [SCALE_W-1:0] SC_C100 = 27'd100;
  localparam logic [SCALE_W-1:0] SC_C10  = 27'd10;
  localparam logic [SCALE_W-1:0] SC_ONE  = 27'd1;

  // parser -> accumulator: one add request per character
  typedef struct packed {
    logic                   last;
    err_t                   err;
    logic [NUM_W_MAX-1:0]   num;
    logic [SCALE_W-1:0]     scale;
  } req_t;

  // pipeline enables from the top level
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic take3;
  } pipe_ctl_t;

  // accumulator result for the word in its last stage
  typedef struct packed {
    logic                 last;
    err_t                 status;
    logic [TOTAL_W-1:0]   total;
  } res_t;

endpackage

// File: rtl/dur_parse.sv
// Character parser: stage, error, number and digit count per character.
// Depends on dur_pkg. Emits a registered add request per step.
`timescale 1ns / 1ps

module dur_parse import dur_pkg::*; #(
  parameter int NUMBER_WIDTH = NUM_W_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] symbol,
  input  logic       last,
  output req_t       req
);

  stage_t                  stage, stage_next;
  err_t                    err, err_next, err_fin;
  logic [NUMBER_WIDTH-1:0] num, num_next;
  logic [1:0]              dcount, dcount_next;
  logic [SCALE_W-1:0]      scale;

  logic                    is_digit;
  logic [7:0]              digit_raw;
  logic [NUMBER_WIDTH+3:0] num_wide, num10;
  logic                    num10_ovf;
  logic                    take_dig, postfix;

  assign is_digit  = (symbol >= CH_0) && (symbol <= CH_9);
  assign digit_raw = symbol - CH_0;
  assign num_wide  = (NUMBER_WIDTH+4)'(num);
  // n*10 + d as two shifts and adds
  assign num10     = (num_wide << 3) + (num_wide << 1) + (NUMBER_WIDTH+4)'(digit_raw[3:0]);
  assign num10_ovf = |num10[NUMBER_WIDTH+3:NUMBER_WIDTH];

  always_comb begin
    stage_next  = stage;
    err_next    = err;
    num_next    = num;
    dcount_next = dcount;
    scale       = SC_NONE;
    take_dig    = 1'b0;
    postfix     = 1'b0;
    if (err == E_NONE) begin
      if (dcount == 2'd0) begin
        priority if (stage == ST_P) begin
          if (symbol != CH_P) err_next = E_NO_P;
          else stage_next = ST_DAYS;
        end else if (stage == ST_DAYS && symbol == CH_T) begin
          stage_next = ST_HOURS;
        end else if (is_digit) begin
          take_dig = 1'b1;
        end else begin
          err_next = E_NO_DIGITS;
        end
      end else if (is_digit) begin
        take_dig = 1'b1;
      end else begin
        postfix = 1'b1;
      end

      if (take_dig) begin
        if (num10_ovf) begin
          err_next = E_OVERFLOW;
        end else begin
          num_next = num10[NUMBER_WIDTH-1:0];
          if (dcount != 2'd3) dcount_next = dcount + 2'd1;
        end
      end

      if (postfix) begin
        unique case (symbol)
          CH_D: begin
            if (stage > ST_DAYS) err_next = E_ORDER;
            else scale = SC_DAY;
          end
          CH_H: begin
            if (stage > ST_HOURS) err_next = E_ORDER;
            else scale = SC_HOUR;
          end
          CH_M: begin
            if (stage > ST_MINUTES) err_next = E_ORDER;
            else scale = SC_MIN;
          end
          CH_DOT: begin
            if (stage > ST_SECONDS) begin
              err_next = E_ORDER;
            end else begin
              scale      = SC_SEC;
              stage_next = ST_MILLI;
            end
          end
          CH_S: begin
            // fraction digits are right-padded to three
            priority if (stage <= ST_SECONDS) scale = SC_SEC;
            else if (dcount == 2'd1)          scale = SC_C100;
            else if (dcount == 2'd2)          scale = SC_C10;
            else                              scale = SC_ONE;
            stage_next = ST_MILLI;
          end
          default: err_next = E_UNKNOWN;
        endcase
        num_next    = '0;
        dcount_next = 2'd0;
      end
    end
  end

  // text ending inside a number
  assign err_fin = (last && err_next == E_NONE && dcount_next != 2'd0) ? E_NO_POSTFIX
                                                                        : err_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage  <= ST_P;
      err    <= E_NONE;
      num    <= '0;
      dcount <= 2'd0;
    end else if (step) begin
      if (last) begin
        stage  <= ST_P;
        err    <= E_NONE;
        num    <= '0;
        dcount <= 2'd0;
      end else begin
        stage  <= stage_next;
        err    <= err_next;
        num    <= num_next;
        dcount <= dcount_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      req.last  <= last;
      req.err   <= err_fin;
      req.num   <= NUM_W_MAX'(num);
      req.scale <= scale;
    end
  end

endmodule

// File: rtl/dur_accum.sv
// Millisecond accumulator: split multiply, product merge, running total.
// Depends on dur_pkg. Overflow of the total is sticky until the last word.
`timescale 1ns / 1ps

module dur_accum import dur_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  pipe_ctl_t ctl,
  input  req_t      req,
  output res_t      res
);

  localparam int HALF   = NUM_W_MAX / 2;
  localparam int PROD_W = HALF + SCALE_W;
  localparam int FULL_W = PROD_W + HALF;

  // stage 2: partial products
  logic              last2;
  err_t              err2;
  logic [PROD_W-1:0] lo2, hi2;
  logic [PROD_W-1:0] lo_mul, hi_mul;

  // stage 3: merged product
  logic               last3;
  err_t               err3;
  logic               big3;
  logic [TOTAL_W-1:0] prod3;
  logic [FULL_W-1:0]  full;

  // running total
  logic [TOTAL_W-1:0] total;
  logic               ovf;
  logic [TOTAL_W:0]   sum;
  logic               ovf_all;

  assign lo_mul = PROD_W'(req.num[HALF-1:0]) * PROD_W'(req.scale);
  assign hi_mul = PROD_W'(req.num[NUM_W_MAX-1:HALF]) * PROD_W'(req.scale);

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      last2 <= req.last;
      err2  <= req.err;
      lo2   <= lo_mul;
      hi2   <= hi_mul;
    end
  end

  assign full = {hi2, HALF'(0)} + FULL_W'(lo2);

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      last3 <= last2;
      err3  <= err2;
      big3  <= |full[FULL_W-1:TOTAL_W];
      prod3 <= full[TOTAL_W-1:0];
    end
  end

  assign sum     = {1'b0, total} + {1'b0, prod3};
  assign ovf_all = ovf || big3 || sum[TOTAL_W];

  // an overflow always precedes any parse error still reported with it
  always_comb begin
    res.last   = last3;
    res.status = ovf_all ? E_OVERFLOW : err3;
    res.total  = (res.status == E_NONE) ? sum[TOTAL_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      ovf   <= 1'b0;
    end else if (ctl.take3) begin
      if (last3) begin
        total <= '0;
        ovf   <= 1'b0;
      end else begin
        if (!ovf_all) total <= sum[TOTAL_W-1:0];
        ovf <= ovf_all;
      end
    end
  end

endmodule

// File: rtl/duration_string_parser.sv
// Top level of the duration text parser.
// Depends on dur_pkg, dur_parse and dur_accum.
`timescale 1ns / 1ps

// Parses ISO 8601 style durations such as "P1DT2H3M4.250S", one ASCII
// character per input word, with last marking the final character. Only the
// word with last set produces an output word: status (0 ok, 1 no leading P,
// 2 no digits, 3 missing postfix, 4 out of order, 5 unknown postfix,
// 6 overflow) and total_ms, which is zero unless status is ok. The first error
// in a text is the one reported; the parser is ready for a new text right
// after a last word. Throughput is one character per clock unless the output
// stalls. The input register loads at acceptance, then come parse, partial
// products (two 32x27 multiplies), product merge, then the total add and
// overflow check into the output register.
// Backpressure on the output only stalls once a last word reaches the final
// stage; characters keep flowing into the empty stages behind it.
// NUMBER_WIDTH (32..64) sets the width of the number register; longer
// numbers report overflow.

module duration_string_parser import dur_pkg::*; #(
  parameter int NUMBER_WIDTH = NUM_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         symbol,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [TOTAL_W-1:0] total_ms
);

  // stage valids
  logic r0_valid, r1_valid, r2_valid, r3_valid;
  // input register
  logic [7:0] r0_symbol;
  logic       r0_last;

  logic rdy1, rdy2, rdy3;
  logic mv0, mv1, mv2, take3;
  logic in_take;

  req_t      req;
  res_t      res;
  pipe_ctl_t ctl;

  err_t               status_r;
  logic [TOTAL_W-1:0] total_r;

  // only a last word needs the output register
  assign take3    = r3_valid && (!res.last || !out_valid || out_ready);
  assign rdy3     = !r3_valid || take3;
  assign rdy2     = !r2_valid || rdy3;
  assign rdy1     = !r1_valid || rdy2;
  assign in_ready = !r0_valid || rdy1;
  assign in_take  = in_valid && in_ready;

  assign mv0 = r0_valid && rdy1;   // parse step, loads r1
  assign mv1 = r1_valid && rdy2;   // loads partial products
  assign mv2 = r2_valid && rdy3;   // loads merged product

  assign ctl.ld2   = mv1;
  assign ctl.ld3   = mv2;
  assign ctl.take3 = take3;

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid  <= 1'b0;
      r1_valid  <= 1'b0;
      r2_valid  <= 1'b0;
      r3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      r0_valid  <= in_take || (r0_valid && !rdy1);
      r1_valid  <= mv0 || (r1_valid && !rdy2);
      r2_valid  <= mv1 || (r2_valid && !rdy3);
      r3_valid  <= mv2 || (r3_valid && !take3);
      out_valid <= (out_valid && !out_ready) || (take3 && res.last);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      r0_symbol <= symbol;
      r0_last   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (take3 && res.last) begin
      status_r <= res.status;
      total_r  <= res.total;
    end
  end

  assign status   = status_r;
  assign total_ms = total_r;

  dur_parse #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (mv0),
    .symbol (r0_symbol),
    .last   (r0_last),
    .req    (req)
  );

  dur_accum u_accum (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req),
    .res (res)
  );

  // a failed text never reports a duration
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_r != E_NONE |-> total_ms == '0)
    else $error("nonzero total with error status");

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // a full pipe stalled at the output backs up to the input
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    r0_valid && r1_valid && r2_valid && r3_valid && !take3 |-> !in_ready)
    else $error("input accepted into a stalled full pipe");

endmodule

// File: bench/testbench.sv
// Self-checking bench for duration_string_parser: streams duration texts one
// character per word and checks each status/total_ms word against a predictor.
// Depends on dur_pkg and the duration_string_parser RTL.
`timescale 1ns / 1ps

module testbench import dur_pkg::*;;

  localparam int NUM_W = NUM_W_DEF;
  localparam logic [63:0] NUM_LIMIT   = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUM_W);
  localparam logic [63:0] TOTAL_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MS_PER_DAY  = 64'd86400000;
  localparam logic [63:0] MS_PER_HOUR = 64'd3600000;
  localparam logic [63:0] MS_PER_MIN  = 64'd60000;
  localparam logic [63:0] MS_PER_SEC  = 64'd1000;
  localparam int HOLD_CYCLES = 300;   // long output stall used to back up the pipe
  localparam int DRAIN_CYCLES = 20;   // margin for stray output words after the last run

  typedef struct packed {
    logic [7:0] sym;
    logic       is_last;
  } word_t;

  typedef struct packed {
    err_t               status;
    logic [TOTAL_W-1:0] total;
  } duration_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         symbol = 8'h00;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic [TOTAL_W-1:0] total_ms;

  duration_string_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .symbol    (symbol),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .total_ms  (total_ms)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard state
  word_t       pending_words[$];       // characters waiting for the driver
  duration_t   expected_durations[$];  // one entry per accepted last word
  logic [7:0]  text_buf[$];            // text under construction
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;           // bumped by the sequencer to start a hold
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // ---------------------------------------------------------------------------
  // Parser predictor: shadow state, updated on every accepted word.
  // ---------------------------------------------------------------------------
  stage_t      stage_q  = ST_P;
  err_t        err_q    = E_NONE;
  logic [63:0] num_q    = '0;
  logic [1:0]  digits_q = '0;   // saturates at three
  logic [63:0] total_q  = '0;

  // Only the first error of a text is kept.
  function automatic void record_error(err_t code);
    if (err_q == E_NONE) err_q = code;
  endfunction

  // Adds the current number times scale, flagging a total beyond 2^63-1.
  function automatic void add_units(logic [63:0] scale);
    if (num_q > (TOTAL_LIMIT - total_q) / scale) record_error(E_OVERFLOW);
    else total_q = total_q + num_q * scale;
  endfunction

  function automatic void take_digit(logic [3:0] d);
    if (num_q > (NUM_LIMIT - 64'(d)) / 64'd10) begin
      record_error(E_OVERFLOW);
    end else begin
      num_q = num_q * 64'd10 + 64'(d);
      if (digits_q != 2'd3) digits_q = digits_q + 2'd1;
    end
  endfunction

  // A non-digit after a number closes it: the unit letter sets the scale and
  // the stage-order rule. S after the decimal point scales a fraction to ms.
  function automatic void close_number(logic [7:0] c);
    case (c)
      CH_D: begin
        if (stage_q > ST_DAYS) record_error(E_ORDER);
        else add_units(MS_PER_DAY);
      end
      CH_H: begin
        if (stage_q > ST_HOURS) record_error(E_ORDER);
        else add_units(MS_PER_HOUR);
      end
      CH_M: begin
        if (stage_q > ST_MINUTES) record_error(E_ORDER);
        else add_units(MS_PER_MIN);
      end
      CH_DOT: begin
        if (stage_q > ST_SECONDS) begin
          record_error(E_ORDER);
        end else begin
          add_units(MS_PER_SEC);
          stage_q = ST_MILLI;
        end
      end
      CH_S: begin
        if (stage_q <= ST_SECONDS) add_units(MS_PER_SEC);
        else if (digits_q == 2'd1) add_units(64'd100);
        else if (digits_q == 2'd2) add_units(64'd10);
        else add_units(64'd1);
        stage_q = ST_MILLI;
      end
      default: record_error(E_UNKNOWN);
    endcase
    num_q = '0;
    digits_q = '0;
  endfunction

  // One accepted character; a last word queues the expected output word.
  function automatic void parse_char(logic [7:0] c, logic is_last);
    duration_t res;
    logic is_digit;
    is_digit = (c >= CH_0) && (c <= CH_9);
    if (err_q == E_NONE) begin
      if (digits_q == 2'd0) begin
        if (stage_q == ST_P) begin
          if (c != CH_P) record_error(E_NO_P);
          else stage_q = ST_DAYS;
        end else if (stage_q == ST_DAYS && c == CH_T) begin
          stage_q = ST_HOURS;
        end else if (is_digit) begin
          take_digit(4'(c - CH_0));
        end else begin
          record_error(E_NO_DIGITS);
        end
      end else if (is_digit) begin
        take_digit(4'(c - CH_0));
      end else begin
        close_number(c);
      end
    end
    if (is_last) begin
      if (err_q == E_NONE && digits_q != 2'd0) record_error(E_NO_POSTFIX);
      res.status = err_q;
      res.total  = (err_q == E_NONE) ? total_q[TOTAL_W-1:0] : '0;
      expected_durations.push_back(res);
      stage_q  = ST_P;
      err_q    = E_NONE;
      num_q    = '0;
      digits_q = '0;
      total_q  = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predicts on acceptance, then offers the next queued word unless
  // the idle roll says to leave a gap. Gaps only fall between words.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(symbol, last);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          symbol   <= w.sym;
          last     <= w.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold counted here when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: every accepted output word must match the oldest expectation.
  always @(posedge clk) begin : check
    duration_t exp_word;
    if (!rst && out_valid && out_ready) begin
      if (expected_durations.size() == 0) begin
        $error("unexpected output word: status %0d total_ms %0d", status, total_ms);
        fail_count++;
      end else begin
        exp_word = expected_durations.pop_front();
        if (status !== exp_word.status) begin
          $error("status: expected %0d, got %0d", exp_word.status, status);
          fail_count++;
        end
        if (total_ms !== exp_word.total) begin
          $error("total_ms: expected %0d, got %0d", exp_word.total, total_ms);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Text builders
  // ---------------------------------------------------------------------------
  task automatic put_string(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic put_digits(int unsigned n);
    repeat (n) text_buf.push_back(CH_0 + 8'($urandom_range(9)));
  endtask

  // Mostly short numbers, sometimes long enough to overflow.
  task automatic put_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) put_digits($urandom_range(1, 3));
    else if (r < 85) put_digits($urandom_range(4, 8));
    else if (r < 95) put_digits($urandom_range(9, 15));
    else put_digits($urandom_range(16, 21));
  endtask

  function automatic logic [7:0] any_postfix();
    case ($urandom_range(4))
      0: return CH_D;
      1: return CH_H;
      2: return CH_M;
      3: return CH_S;
      default: return CH_DOT;
    endcase
  endfunction

  // P [nD] [T] [nH] [nM] [n(S | .fS)], the H unit sometimes repeated
  task automatic well_formed();
    text_buf.push_back(CH_P);
    if ($urandom_range(2) != 0) begin
      put_value();
      text_buf.push_back(CH_D);
    end
    if ($urandom_range(3) != 0) text_buf.push_back(CH_T);
    if ($urandom_range(1)) begin
      put_value();
      text_buf.push_back(CH_H);
      if ($urandom_range(9) == 0) begin
        put_value();
        text_buf.push_back(CH_H);
      end
    end
    if ($urandom_range(1)) begin
      put_value();
      text_buf.push_back(CH_M);
    end
    if ($urandom_range(2) != 0) begin
      put_value();
      if ($urandom_range(1)) begin
        text_buf.push_back(CH_DOT);
        put_digits($urandom_range(1, 4));
      end
      text_buf.push_back(CH_S);
    end
  endtask

  // Break a good text: replace, insert or drop one character.
  task automatic mutate();
    int unsigned pos;
    pos = $urandom_range(text_buf.size() - 1);
    case ($urandom_range(2))
      0: text_buf[pos] = 8'($urandom_range(255));
      1: text_buf.insert(pos, any_postfix());
      default: if (text_buf.size() > 1) text_buf.delete(pos);
    endcase
  endtask

  // Hand the built text to the driver, last flag on its final character.
  task automatic flush_text();
    word_t w;
    foreach (text_buf[i]) begin
      w.sym = text_buf[i];
      w.is_last = (i == text_buf.size() - 1);
      pending_words.push_back(w);
      words_queued++;
    end
    text_buf.delete();
  endtask

  task automatic random_texts(int unsigned n_words);
    string soup;
    int unsigned goal;
    int unsigned r;
    soup = "PTDHMS.0123456789";
    goal = words_queued + n_words;
    while (words_queued < goal) begin
      r = $urandom_range(99);
      if (r < 65) begin
        well_formed();
      end else if (r < 78) begin
        well_formed();
        mutate();
      end else if (r < 86) begin
        // large counts: number register or total overflow
        text_buf.push_back(CH_P);
        put_digits($urandom_range(11, 22));
        text_buf.push_back(any_postfix());
      end else if (r < 93) begin
        repeat ($urandom_range(1, 12)) text_buf.push_back(soup[$urandom_range(soup.len() - 1)]);
      end else begin
        if ($urandom_range(1)) text_buf.push_back(CH_P);
        repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));
      end
      flush_text();
    end
  endtask

  // Sender pause: hold off until every queued word is in and answered.
  task automatic drain();
    while (words_accepted != words_queued || expected_durations.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n);
    @(negedge clk);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    random_texts(n);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: bare P and PT, missing P (0xFF), no digits (0x00), missing
    // postfix, out of order, unknown postfix, fraction widths, H without T,
    // repeated unit, number overflow, total overflow
    put_string("P");                      flush_text();
    put_string("PT");                     flush_text();
    text_buf.push_back(8'hFF);            flush_text();
    text_buf = '{CH_P, 8'h00};            flush_text();
    put_string("P12");                    flush_text();
    put_string("PT1H2D");                 flush_text();
    put_string("P7Q");                    flush_text();
    put_string("PT4.250S");               flush_text();
    put_string("PT1.5S");                 flush_text();
    put_string("PT1.25S");                flush_text();
    put_string("PT1.1234S");              flush_text();
    put_string("P2H1D1D");                flush_text();
    put_string("P99999999999999999999D"); flush_text();
    put_string("P106751991168D");         flush_text();
    drain();

    run_phase(0, 0, 450);

    // long output hold while the sender keeps going: the pipe backs up
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    random_texts(200);
    drain();

    run_phase(68, 0, 400);
    run_phase(0, 68, 400);
    run_phase(18, 18, 400);

    // catch stray output words after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_durations.size() != 0) fail_count++;
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
